### src/sdr_pkg.sv
// Shared constants and types for the spectrum decimator and requantizer.
`default_nettype none
package sdr_pkg;

    localparam int SUM_W        = 46;
    localparam int SAMPLE_W     = 32;
    localparam int CHAN_W       = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int QUOT_W       = 8;
    localparam int REM_W        = SUM_W + QUOT_W + 1;
    localparam int QUEUE_DEPTH  = 4;

    localparam int DEF_MAX_OUT_CHANNELS  = 4096;
    localparam int DEF_MAX_FREQ_COLLAPSE = 64;
    localparam int DEF_MAX_TIME_COLLAPSE = 256;
    localparam int DEF_SAMPLE_BITS       = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_COLLAPSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_COLLAPSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MODE      = 3'd5;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ACC,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage
`default_nettype wire

### src/sdr_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

### src/sdr_queue.sv
// Small flop-based FIFO between the front and back parts.
`default_nettype none
module sdr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sdr_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head,
    output logic                  empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];
    assign count = cnt_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### src/sdr_front.sv
// Front part: channel, group and spectrum counters that classify each item.
`default_nettype none
module sdr_front #(
    parameter int IDX_W = 12,
    parameter int CIG_W = 6,
    parameter int SIB_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [IDX_W-1:0] oc_last,
    input  wire logic [CIG_W-1:0] fc_last,
    input  wire logic [SIB_W-1:0] tc_last,
    output logic      [IDX_W-1:0] idx,
    output logic                  first,
    output logic                  emit,
    output logic                  last_oc
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CIG_W-1:0] cig_reg, cig_next;
    logic [SIB_W-1:0] sib_reg, sib_next;
    logic             last_ch;
    logic             last_sp;

    assign last_ch = (cig_reg >= fc_last);
    assign last_sp = (sib_reg >= tc_last);
    assign last_oc = (idx_reg >= oc_last);
    assign idx     = idx_reg;
    assign first   = (sib_reg == '0) && (cig_reg == '0);
    assign emit    = last_ch && last_sp;

    always_comb begin
        idx_next = idx_reg;
        cig_next = cig_reg;
        sib_next = sib_reg;
        if (accept) begin
            if (last_ch) begin
                cig_next = '0;
                if (last_oc) begin
                    idx_next = '0;
                    sib_next = last_sp ? '0 : sib_reg + 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end else begin
                cig_next = cig_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            cig_reg <= '0;
            sib_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            cig_reg <= cig_next;
            sib_reg <= sib_next;
        end
    end

endmodule
`default_nettype wire

### src/sdr_back.sv
// Back part: accumulator read-modify-write, requantizer divider and output register.
`default_nettype none
module sdr_back #(
    parameter int MAX_OUT_CHANNELS = sdr_pkg::DEF_MAX_OUT_CHANNELS,
    parameter int IDX_W = 12
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_empty,
    output logic                            q_pop,
    input  wire logic [sdr_pkg::SUM_W-1:0]  q_sample,
    input  wire logic [IDX_W-1:0]           q_idx,
    input  wire logic                       q_first,
    input  wire logic                       q_emit,
    input  wire logic                       q_last_oc,
    input  wire logic [sdr_pkg::SUM_W-1:0]  quant_min,
    input  wire logic [sdr_pkg::SUM_W-1:0]  quant_max,
    input  wire logic                       out_mode,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [sdr_pkg::SUM_W-1:0]       m_value,
    output logic [IDX_W-1:0]                m_idx,
    output logic                            m_last,
    output sdr_pkg::back_state_t            state,
    output logic [sdr_pkg::REM_W-1:0]       rem,
    output logic [sdr_pkg::REM_W-1:0]       den_shifted
);

    localparam int SUM_W  = sdr_pkg::SUM_W;
    localparam int REM_W  = sdr_pkg::REM_W;
    localparam int QUOT_W = sdr_pkg::QUOT_W;

    sdr_pkg::back_state_t state_reg, state_next;

    logic [SUM_W-1:0]      sample_reg, sample_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  first_reg, first_next;
    logic                  emit_reg, emit_next;
    logic                  last_oc_reg, last_oc_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [SUM_W-1:0]      den_reg, den_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;
    logic [2:0]            bit_reg, bit_next;
    logic [SUM_W-1:0]      value_reg, value_next;

    logic [SUM_W-1:0]      rd_data;
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      clipped;
    logic [SUM_W-1:0]      diff;
    logic [REM_W-1:0]      trial;
    logic                  empty_range;

    sdr_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_OUT_CHANNELS),
        .ADDR_W(IDX_W)
    ) u_sums (
        .aclk   (aclk),
        .wr_en  (state_reg == sdr_pkg::B_ACC),
        .wr_addr(idx_reg),
        .wr_data(sum),
        .rd_addr(q_idx),
        .rd_data(rd_data)
    );

    assign sum         = first_reg ? sample_reg : rd_data + sample_reg;
    assign empty_range = (quant_max <= quant_min);
    assign clipped     = (sum > quant_max) ? quant_max :
                         (sum < quant_min) ? quant_min : sum;
    assign diff        = clipped - quant_min;
    assign den_shifted = REM_W'(den_reg) << bit_reg;
    assign trial       = rem_reg - den_shifted;
    assign rem         = rem_reg;
    assign state       = state_reg;
    assign q_pop       = (state_reg == sdr_pkg::B_IDLE) && !q_empty;
    assign m_valid     = (state_reg == sdr_pkg::B_OUT);
    assign m_value     = value_reg;
    assign m_idx       = idx_reg;
    assign m_last      = last_oc_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sdr_pkg::B_IDLE: if (!q_empty) begin
                state_next = sdr_pkg::B_ACC;
            end
            sdr_pkg::B_ACC: begin
                if (!emit_reg) begin
                    state_next = sdr_pkg::B_IDLE;
                end else if (out_mode || empty_range) begin
                    state_next = sdr_pkg::B_OUT;
                end else begin
                    state_next = sdr_pkg::B_DIV;
                end
            end
            sdr_pkg::B_DIV: if (bit_reg == '0) begin
                state_next = sdr_pkg::B_OUT;
            end
            sdr_pkg::B_OUT: if (m_ready) begin
                state_next = sdr_pkg::B_IDLE;
            end
            default: state_next = sdr_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        sample_next  = sample_reg;
        idx_next     = idx_reg;
        first_next   = first_reg;
        emit_next    = emit_reg;
        last_oc_next = last_oc_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        quot_next    = quot_reg;
        bit_next     = bit_reg;
        value_next   = value_reg;
        unique case (state_reg)
            sdr_pkg::B_IDLE: if (!q_empty) begin
                sample_next  = q_sample;
                idx_next     = q_idx;
                first_next   = q_first;
                emit_next    = q_emit;
                last_oc_next = q_last_oc;
            end
            sdr_pkg::B_ACC: begin
                // (d - min) * 255 as a shift and subtract
                rem_next   = (REM_W'(diff) << QUOT_W) - REM_W'(diff);
                den_next   = quant_max - quant_min;
                quot_next  = '0;
                bit_next   = 3'(QUOT_W - 1);
                value_next = out_mode ? sum : '0;
            end
            sdr_pkg::B_DIV: begin
                // restoring division, one quotient bit per cycle
                if (!trial[REM_W-1]) begin
                    rem_next           = trial;
                    quot_next[bit_reg] = 1'b1;
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    value_next = SUM_W'({quot_next});
                end
            end
            sdr_pkg::B_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sdr_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        idx_reg     <= idx_next;
        first_reg   <= first_next;
        emit_reg    <= emit_next;
        last_oc_reg <= last_oc_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        quot_reg    <= quot_next;
        bit_reg     <= bit_next;
        value_reg   <= value_next;
    end

endmodule
`default_nettype wire

### src/spectrum_decimate_requantize.sv
// Top level of the filterbank time/frequency decimator with 8-bit requantizer.
// Power samples enter one item per channel, spectrum after spectrum; groups of
// freq_collapse channels are summed over time_collapse spectra in a
// MAX_OUT_CHANNELS-deep accumulator RAM, and one result item leaves per
// finished group (quantized to 0..255, or the raw 46-bit sum when out_mode is
// 1). A four-item queue decouples the input counters from the back end. The
// back end handles one item at a time: its idle state pops the queue and issues
// the registered accumulator RAM read, and its accumulate state writes back the
// updated sum; a raw result or the zero of an empty quantization range then goes
// straight to the output register, while a quantized result first takes its 8
// quotient bits from a restoring divider at one bit per cycle. Results wait in
// the output register for m_ready while the queue keeps taking input items.
`default_nettype none
module spectrum_decimate_requantize #(
    parameter int MAX_OUT_CHANNELS  = sdr_pkg::DEF_MAX_OUT_CHANNELS,
    parameter int MAX_FREQ_COLLAPSE = sdr_pkg::DEF_MAX_FREQ_COLLAPSE,
    parameter int MAX_TIME_COLLAPSE = sdr_pkg::DEF_MAX_TIME_COLLAPSE,
    parameter int SAMPLE_BITS       = sdr_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [sdr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sdr_pkg::SUM_W-1:0]           cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [sdr_pkg::SAMPLE_W-1:0]        s_sample,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [sdr_pkg::SUM_W-1:0]                m_value,
    output logic [sdr_pkg::CHAN_W-1:0]               m_out_channel,
    output logic                                     m_last_of_spectrum
);

    localparam int SUM_W   = sdr_pkg::SUM_W;
    localparam int REM_W   = sdr_pkg::REM_W;
    localparam int IDX_W   = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int CIG_W   = (MAX_FREQ_COLLAPSE > 1) ? $clog2(MAX_FREQ_COLLAPSE) : 1;
    localparam int SIB_W   = (MAX_TIME_COLLAPSE > 1) ? $clog2(MAX_TIME_COLLAPSE) : 1;
    localparam int ENTRY_W = SAMPLE_BITS + IDX_W + 3;
    localparam int CNT_W   = $clog2(sdr_pkg::QUEUE_DEPTH + 1);

    logic [12:0]      out_channels_reg;
    logic [6:0]       freq_collapse_reg;
    logic [8:0]       time_collapse_reg;
    logic [SUM_W-1:0] quant_min_reg;
    logic [SUM_W-1:0] quant_max_reg;
    logic             out_mode_reg;

    logic [31:0]      oc_lim, fc_lim, tc_lim;
    logic [IDX_W-1:0] oc_last;
    logic [CIG_W-1:0] fc_last;
    logic [SIB_W-1:0] tc_last;

    logic             accept;
    logic [IDX_W-1:0] f_idx;
    logic             f_first, f_emit, f_last_oc;
    logic [ENTRY_W-1:0] push_data, head;
    logic             q_full, q_empty, q_pop;
    logic [CNT_W-1:0] q_count;

    logic [IDX_W-1:0] b_idx;
    sdr_pkg::back_state_t b_state;
    logic [REM_W-1:0] b_rem, b_den_shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_channels_reg  <= 13'd128;
            freq_collapse_reg <= 7'd1;
            time_collapse_reg <= 9'd1;
            quant_min_reg     <= '0;
            quant_max_reg     <= '1;
            out_mode_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sdr_pkg::REG_OUT_CHANNELS:  out_channels_reg  <= cfg_wdata[12:0];
                sdr_pkg::REG_FREQ_COLLAPSE: freq_collapse_reg <= cfg_wdata[6:0];
                sdr_pkg::REG_TIME_COLLAPSE: time_collapse_reg <= cfg_wdata[8:0];
                sdr_pkg::REG_QUANT_MIN:     quant_min_reg     <= cfg_wdata;
                sdr_pkg::REG_QUANT_MAX:     quant_max_reg     <= cfg_wdata;
                sdr_pkg::REG_OUT_MODE:      out_mode_reg      <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, values above the maximum act as the maximum
    assign oc_lim = (out_channels_reg == '0) ? 32'd1 :
                    (32'(out_channels_reg) > 32'(MAX_OUT_CHANNELS)) ?
                    32'(MAX_OUT_CHANNELS) : 32'(out_channels_reg);
    assign fc_lim = (freq_collapse_reg == '0) ? 32'd1 :
                    (32'(freq_collapse_reg) > 32'(MAX_FREQ_COLLAPSE)) ?
                    32'(MAX_FREQ_COLLAPSE) : 32'(freq_collapse_reg);
    assign tc_lim = (time_collapse_reg == '0) ? 32'd1 :
                    (32'(time_collapse_reg) > 32'(MAX_TIME_COLLAPSE)) ?
                    32'(MAX_TIME_COLLAPSE) : 32'(time_collapse_reg);
    assign oc_last = IDX_W'(oc_lim - 32'd1);
    assign fc_last = CIG_W'(fc_lim - 32'd1);
    assign tc_last = SIB_W'(tc_lim - 32'd1);

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    sdr_front #(
        .IDX_W(IDX_W),
        .CIG_W(CIG_W),
        .SIB_W(SIB_W)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .accept (accept),
        .oc_last(oc_last),
        .fc_last(fc_last),
        .tc_last(tc_last),
        .idx    (f_idx),
        .first  (f_first),
        .emit   (f_emit),
        .last_oc(f_last_oc)
    );

    assign push_data = {s_sample[SAMPLE_BITS-1:0], f_idx, f_first, f_emit, f_last_oc};

    sdr_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(sdr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_data(push_data),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .count    (q_count)
    );

    sdr_back #(
        .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
        .IDX_W           (IDX_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_sample   (SUM_W'(head[ENTRY_W-1 -: SAMPLE_BITS])),
        .q_idx      (head[IDX_W+2:3]),
        .q_first    (head[2]),
        .q_emit     (head[1]),
        .q_last_oc  (head[0]),
        .quant_min  (quant_min_reg),
        .quant_max  (quant_max_reg),
        .out_mode   (out_mode_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value    (m_value),
        .m_idx      (b_idx),
        .m_last     (m_last_of_spectrum),
        .state      (b_state),
        .rem        (b_rem),
        .den_shifted(b_den_shifted)
    );

    assign m_out_channel = sdr_pkg::CHAN_W'(b_idx);

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CNT_W'(sdr_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        b_state == sdr_pkg::B_DIV |=>
            b_state == sdr_pkg::B_DIV || b_state == sdr_pkg::B_OUT)
        else $error("divider left without a result");

    // partial remainder stays below twice the shifted divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_state == sdr_pkg::B_DIV |-> b_rem < (b_den_shifted << 1))
        else $error("divider remainder out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty && b_state == sdr_pkg::B_IDLE)
        else $error("pop while back end busy or queue empty");

endmodule
`default_nettype wire

### verif/tb_spectrum_decimate_requantize.sv
// Testbench for the spectrum decimator and requantizer with a self-checking scoreboard.
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
    logic [sdr_pkg::SUM_W-1:0]  value;
    logic [sdr_pkg::CHAN_W-1:0] channel;
    logic                       last;
} decim_result_t;

class decim_scoreboard;
    logic [12:0] out_channels;
    logic [6:0]  freq_collapse;
    logic [8:0]  time_collapse;
    logic [45:0] quant_min;
    logic [45:0] quant_max;
    logic        out_mode;

    logic [45:0] acc [4096];
    int unsigned chan_idx;
    int unsigned chan_in_group;
    int unsigned spec_in_block;

    decim_result_t pending_results[$];
    int errors;

    function new();
        out_channels  = 13'd128;
        freq_collapse = 7'd1;
        time_collapse = 9'd1;
        quant_min     = '0;
        quant_max     = '1;
        out_mode      = 1'b0;
        chan_idx      = 0;
        chan_in_group = 0;
        spec_in_block = 0;
        errors        = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [45:0] data);
        case (idx)
            sdr_pkg::REG_OUT_CHANNELS:  out_channels  = data[12:0];
            sdr_pkg::REG_FREQ_COLLAPSE: freq_collapse = data[6:0];
            sdr_pkg::REG_TIME_COLLAPSE: time_collapse = data[8:0];
            sdr_pkg::REG_QUANT_MIN:     quant_min     = data;
            sdr_pkg::REG_QUANT_MAX:     quant_max     = data;
            sdr_pkg::REG_OUT_MODE:      out_mode      = data[0];
            default: ;
        endcase
    endfunction

    static function int unsigned limit(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function int unsigned eff_oc();
        return limit(out_channels, 4096);
    endfunction

    function int unsigned block_items();
        return limit(out_channels, 4096) * limit(freq_collapse, 64)
               * limit(time_collapse, 256);
    endfunction

    function longint unsigned requantize(longint unsigned d);
        longint unsigned lo;
        longint unsigned hi;
        lo = quant_min;
        hi = quant_max;
        if (hi <= lo) return 0;
        if (d > hi) d = hi;
        if (d < lo) d = lo;
        return ((d - lo) * 255) / (hi - lo);
    endfunction

    function void note_sample(logic [31:0] sample);
        int unsigned fc;
        int unsigned tc;
        int unsigned idx;
        bit last_ch;
        bit last_sp;
        bit last_oc;
        decim_result_t r;
        fc = limit(freq_collapse, 64);
        tc = limit(time_collapse, 256);
        idx = chan_idx;
        last_ch = chan_in_group >= fc - 1;
        last_sp = spec_in_block >= tc - 1;
        last_oc = idx >= eff_oc() - 1;
        if (idx >= 4096) idx = 4095;
        if (spec_in_block == 0 && chan_in_group == 0)
            acc[idx] = {14'd0, sample};
        else
            acc[idx] = acc[idx] + {14'd0, sample};
        if (last_ch && last_sp) begin
            r.value   = out_mode ? acc[idx] : 46'(requantize(acc[idx]));
            r.channel = idx[11:0];
            r.last    = last_oc;
            pending_results.push_back(r);
        end
        if (last_ch) begin
            chan_in_group = 0;
            if (last_oc) begin
                chan_idx = 0;
                spec_in_block = last_sp ? 0 : spec_in_block + 1;
            end else begin
                chan_idx = idx + 1;
            end
        end else begin
            chan_in_group++;
        end
    endfunction

    function void check_result(decim_result_t got);
        decim_result_t want;
        if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: value=%0d ch=%0d last=%0b",
                         got.value, got.channel, got.last);
            return;
        end
        want = pending_results.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: expected value=%0d ch=%0d last=%0b, ",
                          "got value=%0d ch=%0d last=%0b"},
                         want.value, want.channel, want.last,
                         got.value, got.channel, got.last);
        end
    endfunction
endclass

module tb_spectrum_decimate_requantize;

    localparam int DRAIN_CYCLES = 40;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [sdr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sdr_pkg::SUM_W-1:0]     cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [sdr_pkg::SAMPLE_W-1:0]  s_sample = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [sdr_pkg::SUM_W-1:0]     m_value;
    logic [sdr_pkg::CHAN_W-1:0]    m_out_channel;
    logic                          m_last_of_spectrum;

    decim_scoreboard sb;
    int send_idle_pct = 32;
    int recv_idle_pct = 79;
    int samples_sent = 0;

    spectrum_decimate_requantize dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .m_out_channel(m_out_channel), .m_last_of_spectrum(m_last_of_spectrum)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_value, m_out_channel, m_last_of_spectrum});
    end

    // caller lowers cfg_wr_en after the last write of a group
    task automatic write_reg(logic [sdr_pkg::CFG_IDX_W-1:0] idx,
                             logic [sdr_pkg::SUM_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic configure(logic [12:0] oc, logic [6:0] fc, logic [8:0] tc,
                             logic [45:0] qmin, logic [45:0] qmax, logic mode);
        write_reg(sdr_pkg::REG_OUT_CHANNELS, sdr_pkg::SUM_W'(oc));
        write_reg(sdr_pkg::REG_FREQ_COLLAPSE, sdr_pkg::SUM_W'(fc));
        write_reg(sdr_pkg::REG_TIME_COLLAPSE, sdr_pkg::SUM_W'(tc));
        write_reg(sdr_pkg::REG_QUANT_MIN, qmin);
        write_reg(sdr_pkg::REG_QUANT_MAX, qmax);
        write_reg(sdr_pkg::REG_OUT_MODE, sdr_pkg::SUM_W'(mode));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(logic [31:0] sample);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= sample;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(sample);
        samples_sent++;
        if (samples_sent == 650) begin
            send_idle_pct = 79;
            recv_idle_pct = 32;
        end else if (samples_sent == 1300) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2, 3:    return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_blocks(int nblocks, bit big_values);
        int n;
        n = nblocks * sb.block_items();
        repeat (n) send_sample(big_values ? rand_sample() : $urandom_range(0, 1023));
    endtask

    task automatic random_phase();
        logic [12:0] oc;
        logic [6:0]  fc;
        logic [8:0]  tc;
        longint unsigned top;
        longint unsigned lo;
        longint unsigned hi;
        oc = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 8));
        fc = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 4));
        tc = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 4));
        top = 64'd4 * 64'd4 * 64'hFFFF_FFFF;
        lo  = ($urandom_range(0, 3) == 0) ? 0 : {$urandom, $urandom} % (top / 2);
        case ($urandom_range(0, 5))
            0:       hi = (64'd1 << sdr_pkg::SUM_W) - 1;
            1:       hi = lo - (lo != 0 ? $urandom_range(0, 1) : 0);
            default: hi = lo + 1 + {$urandom, $urandom} % top;
        endcase
        configure(oc, fc, tc, sdr_pkg::SUM_W'(lo), sdr_pkg::SUM_W'(hi),
                  1'($urandom_range(0, 1)));
        send_blocks($urandom_range(1, 3), 1'b1);
        wait_idle();
    endtask

    initial begin
        logic [31:0] directed [16];
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, single bits and raw sums
        directed = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h0000_FFFF, 32'hFFFF_0000, 32'h0, 32'h0,
                     32'h0100, 32'h7FFF_FFFF, 32'h0000_0080, 32'hFFFF_FFFE};
        configure(13'd4, 7'd2, 9'd2, '0, '1, 1'b1);
        foreach (directed[i]) send_sample(directed[i]);
        wait_idle();
        // empty quantization range
        configure(13'd2, 7'd1, 9'd1, 46'd5, 46'd5, 1'b0);
        send_sample(32'd3);
        send_sample(32'd900);
        wait_idle();
        // below, at and above the clip bounds
        configure(13'd4, 7'd1, 9'd1, 46'd100, 46'd300, 1'b0);
        send_sample(32'd50);
        send_sample(32'd100);
        send_sample(32'd299);
        send_sample(32'hFFFF_FFFF);
        wait_idle();

        repeat (11) random_phase();

        // largest settings and out-of-range register values
        configure(13'd1, 7'd64, 9'd2, '0, '1, 1'b1);
        send_blocks(1, 1'b1);
        wait_idle();
        configure(13'd300, 7'd1, 9'd1, '1, '1, 1'b0);
        send_blocks(1, 1'b0);
        wait_idle();
        configure(13'd1, 7'd1, 9'h1FF, 46'd0, 46'd1_000_000, 1'b0);
        send_blocks(1, 1'b0);
        wait_idle();
        configure(13'd0, 7'h7F, 9'd0, '0, '1, 1'b1);
        send_blocks(1, 1'b1);
        wait_idle();

        repeat (11) random_phase();

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
